// ===== sv/mlbc_pkg.sv =====
`default_nettype none

package mlbc_pkg;

	// Fixed widths of the word fields.
	localparam int FUNC_W    = 3;
	localparam int LED_W     = 3;
	localparam int TIME_IN_W = 15;
	localparam int ELAPSED_W = 16;
	localparam int LEVELS_W  = 8;

	// Command codes carried in func. The codes above FN_PULSE are unused.
	typedef enum logic [FUNC_W-1:0] {
		FN_TICK  = 3'd0,
		FN_ON    = 3'd1,
		FN_OFF   = 3'd2,
		FN_BLINK = 3'd3,
		FN_PULSE = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		MD_OFF   = 2'd0,
		MD_ON    = 2'd1,
		MD_BLINK = 2'd2,
		MD_PULSE = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMD,
		ST_SCAN,
		ST_WAIT,
		ST_DONE
	} state_t;

	// Mode and drive level of one LED, passed to and from the update logic.
	typedef struct packed {
		mode_t mode;
		logic  level;
	} led_ctl_t;

endpackage

`default_nettype wire

// ===== sv/multi_led_blink_controller_unit.sv =====
// Sequence: a tick walks every LED entry in ST_SCAN, then ST_WAIT and ST_DONE; a command
// passes ST_CMD, ST_WAIT and ST_DONE; an unused code or out-of-range LED goes to ST_DONE.
// Throughput: one word at a time; the per-LED memory is walked once per tick with one
// read and one write back per cycle.
// Reset: arst_n clears all LEDs to off and low and all timers to zero at once, through
// per-entry valid bits; no clearing pass is needed.
`default_nettype none

module multi_led_blink_controller_unit #(
	parameter int NUM_LEDS  = 8,
	parameter int TIME_BITS = 15
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [mlbc_pkg::FUNC_W-1:0]      func,
	input  wire logic [mlbc_pkg::LED_W-1:0]       led,
	input  wire logic [mlbc_pkg::TIME_IN_W-1:0]   time_first,
	input  wire logic [mlbc_pkg::TIME_IN_W-1:0]   time_second,
	input  wire logic [mlbc_pkg::ELAPSED_W-1:0]   elapsed,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [mlbc_pkg::LEVELS_W-1:0]         levels
);
	import mlbc_pkg::*;

	localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
	localparam int SHOWN = (NUM_LEDS < LEVELS_W) ? NUM_LEDS : LEVELS_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	// One memory entry holds everything about an LED except its level, which lives
	// in flip-flops so that the whole level vector can be shown at once.
	typedef struct packed {
		mode_t                mode;
		logic [TIME_BITS-1:0] timer;
		logic [TIME_BITS-1:0] on_t;
		logic [TIME_BITS-1:0] off_t;
	} entry_t;

	entry_t               mem [NUM_LEDS];
	logic [NUM_LEDS-1:0]  vld_q;
	logic [NUM_LEDS-1:0]  level_q;

	state_t               state_q;
	state_t               state_d;

	// Captured word.
	logic [FUNC_W-1:0]    func_q;
	logic [LED_W-1:0]     led_q;
	logic [TIME_BITS-1:0] t1_q;
	logic [TIME_BITS-1:0] t2_q;
	logic [ELAPSED_W-1:0] dt_q;

	logic [IDX_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     led_idx;
	logic [IDX_W-1:0]     rd_addr;
	logic                 rd_en;

	// Read stage: registered memory data and the entry it belongs to.
	entry_t               rd_ent_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic                 rd_vld_s1;

	entry_t               cur_ent;
	entry_t               new_ent;
	led_ctl_t             cur_ctl;
	led_ctl_t             new_ctl;

	logic                 out_valid_q;
	logic [LEVELS_W-1:0]  levels_q;

	logic [5:0]           led_in_ext;
	logic                 cmd_ok;
	logic [31:0]          tf_ext;
	logic [31:0]          ts_ext;
	logic [TIME_BITS-1:0] tf_clamp;
	logic [TIME_BITS-1:0] ts_clamp;
	logic                 accept;
	logic                 out_free;
	logic [5:0]           led_q_ext;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// Besides ticks, only the four real commands to an LED that exists touch the memory;
	// anything else goes straight to the result.
	assign led_in_ext = 6'(led);
	assign cmd_ok     = (led_in_ext < 6'(NUM_LEDS)) &&
	                    (func == FN_ON || func == FN_OFF || func == FN_BLINK ||
	                     func == FN_PULSE);

	// Phase times wider than the timer saturate at its largest value.
	assign tf_ext   = 32'(time_first);
	assign ts_ext   = 32'(time_second);
	assign tf_clamp = (tf_ext > 32'(TIME_MAX)) ? TIME_MAX : tf_ext[TIME_BITS-1:0];
	assign ts_clamp = (ts_ext > 32'(TIME_MAX)) ? TIME_MAX : ts_ext[TIME_BITS-1:0];

	assign led_q_ext = 6'(led_q);
	assign led_idx   = led_q_ext[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		rd_en    = 1'b0;
		rd_addr  = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (func == FN_TICK) begin
						state_d = ST_SCAN;
					end else if (cmd_ok) begin
						state_d = ST_CMD;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_CMD: begin
				rd_en   = 1'b1;
				rd_addr = led_idx;
				state_d = ST_WAIT;
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (cnt_q == IDX_W'(NUM_LEDS - 1)) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				// The last entry is written back in this cycle.
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func;
			led_q  <= led;
			t1_q   <= tf_clamp;
			t2_q   <= ts_clamp;
			dt_q   <= elapsed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= '0;
		end else if (state_q == ST_SCAN) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Synchronous memory: one read and one write per cycle, read data registered.
	// During a tick the write back of entry k and the read of entry k + 1 never
	// address the same entry, so no forwarding is needed.
	always_ff @(posedge clk) begin
		rd_ent_s1 <= mem[rd_addr];
		idx_s1    <= rd_addr;
		if (rd_vld_s1) begin
			mem[idx_s1] <= new_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
		end
	end

	// An entry never written since reset reads as its reset value: off, all zero.
	always_comb begin
		cur_ent = vld_q[idx_s1] ? rd_ent_s1 : '0;
		cur_ctl = '{mode: cur_ent.mode, level: level_q[idx_s1]};
	end

	mlbc_led_update #(
		.TIME_BITS (TIME_BITS)
	) u_update (
		.func      (func_q),
		.ctl_in    (cur_ctl),
		.timer_in  (cur_ent.timer),
		.on_in     (cur_ent.on_t),
		.off_in    (cur_ent.off_t),
		.t_first   (t1_q),
		.t_second  (t2_q),
		.dt        (dt_q),
		.ctl_out   (new_ctl),
		.timer_out (new_ent.timer),
		.on_out    (new_ent.on_t),
		.off_out   (new_ent.off_t)
	);

	assign new_ent.mode = new_ctl.mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			level_q <= '0;
		end else if (rd_vld_s1) begin
			vld_q[idx_s1]   <= 1'b1;
			level_q[idx_s1] <= new_ctl.level;
		end
	end

	// Output register: the result word waits here while the next word is taken in.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			levels_q <= LEVELS_W'(level_q[SHOWN-1:0]);
		end
	end

	assign out_valid = out_valid_q;
	assign levels    = levels_q;

	// A read result is only ever pending while an item is being worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_DONE) |-> !rd_vld_s1)
		else $error("memory read pending outside the working states");

	// A new result word appears only as the item finishes.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_DONE))
		else $error("result word raised without a finished item");

	// A finished item with room at the output returns the block to idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (state_q == ST_IDLE && out_valid))
		else $error("finished item did not hand over its result");

endmodule

`default_nettype wire

// ===== sv/mlbc_led_update.sv =====
`default_nettype none

module mlbc_led_update #(
	parameter int TIME_BITS = 15
) (
	input  wire logic [mlbc_pkg::FUNC_W-1:0]    func,
	input  wire mlbc_pkg::led_ctl_t             ctl_in,
	input  wire logic [TIME_BITS-1:0]           timer_in,
	input  wire logic [TIME_BITS-1:0]           on_in,
	input  wire logic [TIME_BITS-1:0]           off_in,
	input  wire logic [TIME_BITS-1:0]           t_first,
	input  wire logic [TIME_BITS-1:0]           t_second,
	input  wire logic [mlbc_pkg::ELAPSED_W-1:0] dt,
	output mlbc_pkg::led_ctl_t                  ctl_out,
	output logic [TIME_BITS-1:0]                timer_out,
	output logic [TIME_BITS-1:0]                on_out,
	output logic [TIME_BITS-1:0]                off_out
);
	import mlbc_pkg::*;

	logic [31:0]          timer_ext;
	logic [31:0]          dt_ext;
	logic [31:0]          diff;
	logic [TIME_BITS-1:0] timer_dec;

	// Timers floor at zero instead of wrapping.
	assign timer_ext = 32'(timer_in);
	assign dt_ext    = 32'(dt);
	assign diff      = timer_ext - dt_ext;
	assign timer_dec = (timer_ext <= dt_ext) ? '0 : diff[TIME_BITS-1:0];

	always_comb begin
		ctl_out   = ctl_in;
		timer_out = timer_in;
		on_out    = on_in;
		off_out   = off_in;
		unique case (func)
			FN_TICK: begin
				if (ctl_in.mode == MD_BLINK || ctl_in.mode == MD_PULSE) begin
					timer_out = timer_dec;
					if (timer_dec == '0) begin
						if (ctl_in.mode == MD_BLINK) begin
							ctl_out.level = ~ctl_in.level;
							timer_out     = ctl_in.level ? off_in : on_in;
						end else begin
							ctl_out.mode  = MD_OFF;
							ctl_out.level = 1'b0;
						end
					end
				end
			end
			FN_ON: begin
				ctl_out.mode  = MD_ON;
				ctl_out.level = 1'b1;
			end
			FN_OFF: begin
				ctl_out.mode  = MD_OFF;
				ctl_out.level = 1'b0;
			end
			FN_BLINK: begin
				// A running timer keeps its phase; only an expired one restarts.
				ctl_out.mode = MD_BLINK;
				on_out       = t_first;
				off_out      = t_second;
				if (timer_in == '0) begin
					timer_out     = t_first;
					ctl_out.level = 1'b1;
				end
			end
			FN_PULSE: begin
				ctl_out.mode  = MD_PULSE;
				timer_out     = t_first;
				ctl_out.level = 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
